/* sv/text_mode_console_writer_macros.svh */
// Assertion macros used by the console writer top level.
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TMCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TMCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TMCW_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TMCW_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/tmcw_pkg.sv */
package tmcw_pkg;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;

   localparam logic [15:0] BLANK_WORD = 16'h0F20;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  char_code;
      logic [3:0]  bg_colour;
      logic [3:0]  fg_colour;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_location;
      logic [15:0] cell_data;
      logic        scrolled;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic read_load;
      logic sweep_clear;
      logic sweep_scroll;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       need_scroll;
      logic       clear_last;
      logic       scroll_last;
   } status_type;

endpackage

/* sv/tmcw_ram.sv */
module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tmcw_datapath.sv */
module tmcw_datapath #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmcw_pkg::req_type    req_payload,
   input  tmcw_pkg::cmd_type    cmd,
   output tmcw_pkg::status_type status,
   output tmcw_pkg::rsp_type    rsp_payload
);
   import tmcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COPY_N = (ROWS - 1) * COLUMNS;
   localparam int AW     = $clog2(CELLS);
   localparam int CNW    = $clog2(CELLS + 1);
   localparam int CW     = $clog2(COLUMNS);
   localparam int CXW    = $clog2(COLUMNS + TAB_WIDTH);
   localparam int RW     = $clog2(ROWS);
   localparam int RXW    = RW + 1;
   localparam int NSTOP  = (COLUMNS - 1) / TAB_WIDTH;

   req_type          req_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic [15:0]      data_ff, data_in;
   logic             scrolled_ff, scrolled_in;

   logic [CXW-1:0]   tab_stop;
   logic [CXW-1:0]   col_step;
   logic [RXW-1:0]   row_step;
   logic             print_put;
   logic             need_scroll;
   logic             read_ok;
   logic [AW-1:0]    loc;
   logic [CNW-1:0]   cnt_m1;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [15:0]      ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [15:0]      ram_rdata;

   // The next tab stop is the smallest multiple of the tab width above the column.
   always_comb begin
      tab_stop = CXW'(TAB_WIDTH);
      for (int k = 1; k <= NSTOP; k++) begin
         if (32'(col_ff) >= k * TAB_WIDTH) begin
            tab_stop = CXW'((k + 1) * TAB_WIDTH);
         end
      end
   end

   always_comb begin
      col_step  = CXW'(col_ff);
      row_step  = RXW'(row_ff);
      print_put = 1'b0;
      case (req_ff.char_code)
         CHAR_BS: begin
            if (col_ff != '0) begin
               col_step = CXW'(col_ff) - CXW'(1);
            end
         end
         CHAR_TAB: col_step = tab_stop;
         CHAR_CR:  col_step = '0;
         CHAR_LF: begin
            col_step = '0;
            row_step = row_step + RXW'(1);
         end
         default: begin
            if (req_ff.char_code inside {[CHAR_SPACE:CHAR_DEL]}) begin
               print_put = 1'b1;
               col_step  = CXW'(col_ff) + CXW'(1);
            end
         end
      endcase
      if (32'(col_step) >= COLUMNS) begin
         col_step = '0;
         row_step = row_step + RXW'(1);
      end
      need_scroll = (32'(row_step) >= ROWS);
   end

   assign loc     = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign read_ok = (32'(req_ff.cell_address) < CELLS);
   assign cnt_m1  = cnt_ff - CNW'(1);

   // Memory ports. A scroll reads one row ahead and writes the registered word back in the cycle after.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = loc;
      ram_wdata = {req_ff.bg_colour, req_ff.fg_colour, req_ff.char_code};
      ram_raddr = AW'(req_ff.cell_address);
      if (cmd.exec) begin
         ram_we = (req_ff.operation == OP_PUT) && print_put;
      end
      if (cmd.sweep_clear) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(cnt_ff);
         ram_wdata = BLANK_WORD;
      end
      if (cmd.sweep_scroll) begin
         ram_raddr = AW'(32'(cnt_ff) + COLUMNS);
         if (cnt_ff != '0) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_m1);
            ram_wdata = (32'(cnt_m1) < COPY_N) ? ram_rdata : BLANK_WORD;
         end
      end
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      cnt_in      = cnt_ff;
      data_in     = data_ff;
      scrolled_in = scrolled_ff;
      if (cmd.exec) begin
         cnt_in      = '0;
         data_in     = '0;
         scrolled_in = 1'b0;
         if (req_ff.operation == OP_PUT) begin
            col_in      = CW'(col_step);
            scrolled_in = need_scroll;
            row_in      = need_scroll ? RW'(ROWS - 1) : RW'(row_step);
         end else if (req_ff.operation == OP_CLEAR) begin
            col_in = '0;
            row_in = '0;
         end
      end
      if (cmd.sweep_clear || cmd.sweep_scroll) begin
         cnt_in = cnt_ff + CNW'(1);
      end
      if (cmd.read_load) begin
         data_in = read_ok ? ram_rdata : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
      data_ff     <= data_in;
      scrolled_ff <= scrolled_in;
   end

   tmcw_ram #(
      .WIDTH(16),
      .DEPTH(CELLS)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign status.op          = req_ff.operation;
   assign status.need_scroll = need_scroll;
   assign status.clear_last  = (32'(cnt_ff) == CELLS - 1);
   assign status.scroll_last = (32'(cnt_ff) == CELLS);

   assign rsp_payload.cursor_location = 11'(32'(loc));
   assign rsp_payload.cell_data       = data_ff;
   assign rsp_payload.scrolled        = scrolled_ff;

endmodule

/* sv/tmcw_ctrl.sv */
module tmcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tmcw_pkg::status_type status,
   output tmcw_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);
   import tmcw_pkg::*;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_EXEC   = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_CLEAR  = 7'b0010000,
      ST_SCROLL = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            // Blank the whole store after reset before taking any request.
            cmd.sweep_clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.op)
               OP_PUT:   state_in = status.need_scroll ? ST_SCROLL : ST_DONE;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ:  state_in = ST_READ;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_READ: begin
            cmd.read_load = 1'b1;
            state_in      = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            cmd.sweep_scroll = 1'b1;
            if (status.scroll_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

/* sv/text_mode_console_writer.sv */
// Text console writer over a COLUMNS x ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte). A request is taken when start is high and
// busy is low; exactly one response follows, shown on rsp_payload for the single
// cycle in which rsp_strobe is high, and it must be captured then as there is no
// back-pressure. A put character or an unused operation goes from acceptance through
// an execute state to the response, and a read cell passes an extra read state for
// the registered read of the cell memory. Clear writes one cell a cycle through the
// single write port; a put character that scrolls copies the store up one row
// through the same port, one cell a cycle. After reset, busy stays high while the
// store is blanked.
`include "text_mode_console_writer_macros.svh"

module text_mode_console_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmcw_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output tmcw_pkg::rsp_type rsp_payload
);
   import tmcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tmcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   tmcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .status     (status),
      .rsp_payload(rsp_payload)
   );

   `TMCW_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy, "response outside a request")
   `TMCW_ASSERT_NXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe, "response repeated")
   `TMCW_ASSERT_NXT(a_no_early_rsp, clock, reset, start && !busy, !rsp_strobe && busy,
                    "response too early after acceptance")
   `TMCW_ASSERT_IMP(a_cursor_range, clock, reset, rsp_strobe,
                    32'(rsp_payload.cursor_location) < COLUMNS * ROWS, "cursor out of range")

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tmcw_pkg::*;

   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = COLS * ROWS;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   // A scrolling put or a clear holds the port while it sweeps every cell, so the limit
   // allows every request to be one of those, three times over.
   localparam int unsigned CYCLE_LIMIT = 3 * (CELLS + 1100 * (CELLS + 4 + 20));

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // Shadow of the console state, advanced once per accepted request.
   logic [15:0] text_cells [CELLS];
   int          cursor_col;
   int          cursor_row;

   rsp_type     owed_replies [$];
   int          sender_idle_pct;
   int          errors;
   int unsigned cycle_count;

   text_mode_console_writer #(
      .COLUMNS  (COLS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_STOP)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_mode_console_writer: mismatch");
         $finish;
      end
   end

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) text_cells[i] = BLANK_WORD;
      cursor_col = 0;
      cursor_row = 0;
   endfunction

   // Works out the response to one request and updates the shadow state.
   function automatic rsp_type apply_to_screen(input req_type r);
      rsp_type o;
      o = '0;
      case (r.operation)
         OP_PUT: begin
            if (r.char_code == CHAR_BS) begin
               if (cursor_col != 0) cursor_col--;
            end else if (r.char_code == CHAR_TAB) begin
               cursor_col = (cursor_col / TAB_STOP + 1) * TAB_STOP;
            end else if (r.char_code == CHAR_CR) begin
               cursor_col = 0;
            end else if (r.char_code == CHAR_LF) begin
               cursor_col = 0;
               cursor_row++;
            end else if (r.char_code >= CHAR_SPACE && r.char_code <= CHAR_DEL) begin
               text_cells[cursor_row * COLS + cursor_col] =
                  {r.bg_colour, r.fg_colour, r.char_code};
               cursor_col++;
            end
            if (cursor_col >= COLS) begin
               cursor_col = 0;
               cursor_row++;
            end
            if (cursor_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLS; i++) text_cells[i] = text_cells[i + COLS];
               for (int i = (ROWS - 1) * COLS; i < CELLS; i++) text_cells[i] = BLANK_WORD;
               cursor_row = ROWS - 1;
               o.scrolled = 1'b1;
            end
         end
         OP_CLEAR: blank_screen();
         OP_READ: begin
            if (r.cell_address < CELLS) o.cell_data = text_cells[r.cell_address];
         end
         default: ;
      endcase
      o.cursor_location = 11'(cursor_row * COLS + cursor_col);
      return o;
   endfunction

   function automatic req_type make_put(input logic [7:0] code, input logic [3:0] back,
                                        input logic [3:0] fore);
      req_type r;
      r.operation    = OP_PUT;
      r.char_code    = code;
      r.bg_colour    = back;
      r.fg_colour    = fore;
      r.cell_address = 11'($urandom_range(0, 2047));
      return r;
   endfunction

   function automatic req_type make_read(input logic [10:0] addr);
      req_type r;
      r              = req_type'($urandom);
      r.operation    = OP_READ;
      r.cell_address = addr;
      return r;
   endfunction

   function automatic logic [3:0] any_color();
      return 4'($urandom_range(0, 15));
   endfunction

   // Each cycle the sender either offers the request or idles; start may stay high
   // after acceptance, and the next request or a drain sets it again.
   task automatic send_request(input req_type r);
      logic taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         start       = ($urandom_range(0, 99) >= sender_idle_pct);
         req_payload = r;
         @(posedge clock);
         taken = start && !busy;
      end
      owed_replies.push_back(apply_to_screen(r));
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (owed_replies.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_payload);
            errors++;
         end else begin
            want = owed_replies.pop_front();
            if (rsp_payload.cursor_location !== want.cursor_location) begin
               $error("cursor_location: expected %0d, got %0d",
                      want.cursor_location, rsp_payload.cursor_location);
               errors++;
            end
            if (rsp_payload.cell_data !== want.cell_data) begin
               $error("cell_data: expected %h, got %h", want.cell_data, rsp_payload.cell_data);
               errors++;
            end
            if (rsp_payload.scrolled !== want.scrolled) begin
               $error("scrolled: expected %0b, got %0b", want.scrolled, rsp_payload.scrolled);
               errors++;
            end
         end
      end
   end

   task automatic test_put_codes();
      send_request(make_put(CHAR_SPACE, 4'h0, 4'h0));
      send_request(make_put(CHAR_DEL, 4'hF, 4'hF));
      send_request(make_put(CHAR_BS, any_color(), any_color()));
      send_request(make_put(CHAR_BS, any_color(), any_color()));
      // Backspace in the first column leaves the cursor where it is.
      send_request(make_put(CHAR_BS, any_color(), any_color()));
      send_request(make_put(CHAR_TAB, any_color(), any_color()));
      send_request(make_put(CHAR_TAB, any_color(), any_color()));
      send_request(make_put(CHAR_CR, any_color(), any_color()));
      send_request(make_put(8'h00, any_color(), any_color()));
      send_request(make_put(8'h1F, any_color(), any_color()));
      send_request(make_put(8'h0B, any_color(), any_color()));
      send_request(make_put(8'h80, any_color(), any_color()));
      send_request(make_put(8'hFF, any_color(), any_color()));
      send_request(make_put(CHAR_LF, any_color(), any_color()));
      send_request(make_put(8'h41, 4'hA, 4'h5));
   endtask

   task automatic test_read_cells();
      send_request(make_read(11'd0));
      send_request(make_read(11'd1));
      send_request(make_read(11'(CELLS - 1)));
      send_request(make_read(11'(CELLS)));
      send_request(make_read(11'h7FF));
   endtask

   task automatic test_unused_operation();
      req_type r;
      r           = '1;
      r.operation = OP_UNUSED;
      send_request(r);
   endtask

   task automatic test_clear_screen();
      req_type r;
      r           = req_type'($urandom);
      r.operation = OP_CLEAR;
      send_request(r);
      send_request(make_read(11'(COLS)));
   endtask

   // A mark on the second row must end up on the first after one line feed past the
   // bottom, and the new last row must be blank.
   task automatic test_scroll();
      send_request(make_put(CHAR_LF, any_color(), any_color()));
      send_request(make_put(8'h51, 4'h3, 4'hC));
      repeat (ROWS - 1) send_request(make_put(CHAR_LF, any_color(), any_color()));
      send_request(make_read(11'd0));
      send_request(make_read(11'((ROWS - 1) * COLS)));
   endtask

   task automatic test_random_traffic(input int count);
      req_type r;
      int      roll;
      int      burst_left;
      int      lf_pct;
      burst_left = 0;
      lf_pct     = 0;
      for (int n = 0; n < count; n++) begin
         // Each burst picks at random between long unbroken text, which reaches the wrap, and
         // short lines, which reach the bottom row and scroll quickly.
         if (burst_left == 0) begin
            burst_left = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
               0:       lf_pct = 1;
               1:       lf_pct = 15;
               default: lf_pct = 30;
            endcase
         end
         burst_left--;
         roll = $urandom_range(0, 999);
         if (roll < 2) begin
            r           = req_type'($urandom);
            r.operation = OP_CLEAR;
         end else if (roll < 12) begin
            r           = req_type'($urandom);
            r.operation = OP_UNUSED;
         end else if (roll < 260) begin
            if ($urandom_range(0, 99) < 90) r = make_read(11'($urandom_range(0, CELLS - 1)));
            else r = make_read(11'($urandom_range(CELLS, 2047)));
         end else begin
            r = make_put(8'($urandom_range(CHAR_SPACE, CHAR_DEL)), any_color(), any_color());
            if ($urandom_range(0, 99) < lf_pct) begin
               r.char_code = CHAR_LF;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll >= 92)      r.char_code = 8'($urandom_range(0, 31));
               else if (roll >= 83) r.char_code = 8'($urandom_range(8'h80, 8'hFF));
               else if (roll >= 79) r.char_code = CHAR_CR;
               else if (roll >= 71) r.char_code = CHAR_BS;
               else if (roll >= 62) r.char_code = CHAR_TAB;
            end
         end
         send_request(r);
      end
   endtask

   initial begin
      start           = 1'b0;
      req_payload     = '0;
      reset           = 1'b1;
      sender_idle_pct = 0;
      errors          = 0;
      cycle_count     = 0;
      blank_screen();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_put_codes();
      test_read_cells();
      test_unused_operation();
      test_clear_screen();
      test_scroll();

      sender_idle_pct = 21;
      test_random_traffic(340);
      sender_idle_pct = 59;
      test_random_traffic(340);
      sender_idle_pct = 0;
      test_random_traffic(340);

      drain();
      repeat (CELLS + 100) @(posedge clock);
      if (errors == 0) begin
         $display("text_mode_console_writer: match");
      end else begin
         $display("text_mode_console_writer: mismatch");
      end
      $finish;
   end

endmodule
